>>> design/rrwd_pkg.sv
// ----------------------------------------------------------------------------
// rrwd_pkg
// Shared types and codes for the round-robin worker dispatch unit: command
// and status codes, the request and response words and the controller
// command group.
// ----------------------------------------------------------------------------
package rrwd_pkg;

   localparam int unsigned WORKER_ID_W = 22;
   localparam int unsigned JOB_W       = 32;

   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UNREGISTER = 2'd1,
      CMD_POST       = 2'd2,
      CMD_CLAIM      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_TURN  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_UNAVAIL   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [WORKER_ID_W-1:0] worker_id;
      logic [JOB_W-1:0]       job_word;
   } req_word_type;

   typedef struct packed {
      status_type       status;
      logic [JOB_W-1:0] job_out;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic commit;
   } ctrl_cmd_type;

endpackage

>>> design/rrwd_ctrl.sv
// ----------------------------------------------------------------------------
// rrwd_ctrl
// Sequencer for the dispatch unit: captures a request word, then commits it
// to the datapath once the response register is free to take the result.
// ----------------------------------------------------------------------------
module rrwd_ctrl
   import rrwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type ctrl
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   // The response register can be reloaded when empty or being emptied now.
   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign ctrl.load_req = (state_ff == S_IDLE) && req_valid;
   assign ctrl.commit   = (state_ff == S_EXEC) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A commit refills the response register; otherwise a response
         // taken by the receiver empties it.
         if ((state_ff == S_EXEC) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> design/rrwd_datapath.sv
// ----------------------------------------------------------------------------
// rrwd_datapath
// Worker table, turn pointer, job mailbox and response register. Each table
// cell compares its ID with the request and shifts from a neighbour on an
// insert or a removal, so every command completes in its commit cycle.
// ----------------------------------------------------------------------------
module rrwd_datapath
   import rrwd_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type ctrl,
   input  req_word_type req_data,
   output rsp_word_type rsp_data
);

   localparam int unsigned IW = $clog2(TABLE_DEPTH);

   req_word_type         req_ff;
   logic [ID_BITS-1:0]   slot_id_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] slot_valid_ff;
   logic [IW-1:0]        turn_ff;
   logic                 mbox_full_ff;
   logic [JOB_W-1:0]     mbox_job_ff;
   rsp_word_type         rsp_ff;
   rsp_word_type         rsp_in;

   logic [ID_BITS-1:0]   key;
   logic [TABLE_DEPTH-1:0] hit;
   logic [TABLE_DEPTH-1:0] below;
   logic [ID_BITS-1:0]   ins_id [TABLE_DEPTH];
   logic [ID_BITS-1:0]   rem_id [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ins;
   logic [TABLE_DEPTH-1:0] valid_rem;
   logic                 have_worker;
   logic                 table_full;
   logic [IW:0]          turn_plus;
   logic [IW-1:0]        turn_claim_in;
   logic [IW-1:0]        turn_reg_in;
   logic [IW-1:0]        turn_dec;
   logic [IW-1:0]        turn_unreg_in;

   assign key         = ID_BITS'(req_ff.worker_id);
   assign have_worker = slot_valid_ff[0];
   assign table_full  = slot_valid_ff[TABLE_DEPTH-1];
   assign valid_ins   = {slot_valid_ff[TABLE_DEPTH-2:0], 1'b1};
   assign valid_rem   = slot_valid_ff & {1'b0, slot_valid_ff[TABLE_DEPTH-1:1]};

   // Per-cell compare and shift sources. The table is sorted, so the cells
   // below the key form a prefix and mark the insertion point.
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      assign hit[k]   = slot_valid_ff[k] && (slot_id_ff[k] == key);
      assign below[k] = slot_valid_ff[k] && (slot_id_ff[k] < key);
      if (k == 0) begin : g_first
         assign ins_id[k] = below[k] ? slot_id_ff[k] : key;
      end else begin : g_rest
         assign ins_id[k] = below[k] ? slot_id_ff[k] :
                            (below[k-1] ? key : slot_id_ff[k-1]);
      end
      if (k == TABLE_DEPTH - 1) begin : g_last
         assign rem_id[k] = slot_id_ff[k];
      end else begin : g_inner
         assign rem_id[k] = below[k] ? slot_id_ff[k] : slot_id_ff[k+1];
      end
   end

   // Turn pointer updates for each command.
   always_comb begin
      turn_plus = {1'b0, turn_ff} + (IW+1)'(1);
      if ((turn_plus < (IW+1)'(TABLE_DEPTH)) && slot_valid_ff[turn_plus[IW-1:0]]) begin
         turn_claim_in = turn_plus[IW-1:0];
      end else begin
         turn_claim_in = '0;
      end

      if (!have_worker) begin
         turn_reg_in = '0;
      end else if (!below[turn_ff]) begin
         turn_reg_in = turn_ff + IW'(1);
      end else begin
         turn_reg_in = turn_ff;
      end

      // Removal of a worker ahead of the turn holder moves the pointer down;
      // a pointer left past the new end wraps to the first entry.
      if (!below[turn_ff] && !hit[turn_ff] && (turn_ff != '0)) begin
         turn_dec = turn_ff - IW'(1);
      end else begin
         turn_dec = turn_ff;
      end
      turn_unreg_in = valid_rem[turn_dec] ? turn_dec : '0;
   end

   // Response word for the command held in the request register.
   always_comb begin
      rsp_in.status  = ST_OK;
      rsp_in.job_out = '0;
      case (req_ff.cmd)
         CMD_REGISTER: begin
            if (!(|hit) && table_full) begin
               rsp_in.status = ST_FULL;
            end
         end
         CMD_UNREGISTER: begin
            if (!(|hit)) begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         CMD_POST: begin
            if (!have_worker || mbox_full_ff) begin
               rsp_in.status = ST_UNAVAIL;
            end
         end
         CMD_CLAIM: begin
            if (!have_worker || !mbox_full_ff) begin
               rsp_in.status = ST_UNAVAIL;
            end else if (!hit[turn_ff]) begin
               rsp_in.status = ST_NOT_TURN;
            end else begin
               rsp_in.job_out = mbox_job_ff;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         req_ff <= req_data;
      end
      if (ctrl.commit) begin
         rsp_ff <= rsp_in;
         case (req_ff.cmd)
            CMD_REGISTER: begin
               if (!(|hit) && !table_full) begin
                  for (int k = 0; k < TABLE_DEPTH; k++) begin
                     slot_id_ff[k] <= ins_id[k];
                  end
               end
            end
            CMD_UNREGISTER: begin
               if (|hit) begin
                  for (int k = 0; k < TABLE_DEPTH; k++) begin
                     slot_id_ff[k] <= rem_id[k];
                  end
               end
            end
            CMD_POST: begin
               if (have_worker && !mbox_full_ff) begin
                  mbox_job_ff <= req_ff.job_word;
               end
            end
            default: begin
               mbox_job_ff <= mbox_job_ff;
            end
         endcase
      end
   end

   // Control state: valid bits, turn pointer and mailbox flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         turn_ff       <= '0;
         mbox_full_ff  <= 1'b0;
      end else if (ctrl.commit) begin
         case (req_ff.cmd)
            CMD_REGISTER: begin
               if (!(|hit) && !table_full) begin
                  slot_valid_ff <= valid_ins;
                  turn_ff       <= turn_reg_in;
               end
            end
            CMD_UNREGISTER: begin
               if (|hit) begin
                  slot_valid_ff <= valid_rem;
                  turn_ff       <= turn_unreg_in;
               end
            end
            CMD_POST: begin
               if (have_worker && !mbox_full_ff) begin
                  mbox_full_ff <= 1'b1;
               end
            end
            CMD_CLAIM: begin
               if (have_worker && mbox_full_ff && hit[turn_ff]) begin
                  mbox_full_ff <= 1'b0;
                  turn_ff      <= turn_claim_in;
               end
            end
            default: begin
               mbox_full_ff <= mbox_full_ff;
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/round_robin_worker_dispatch_unit.sv
// ----------------------------------------------------------------------------
// round_robin_worker_dispatch_unit
// Round-robin dispatch of single jobs to a sorted table of registered workers.
// ----------------------------------------------------------------------------
// Each request word carries one command (register, unregister, post or claim)
// and produces exactly one response word with a status and, for a granted
// claim, the job. A word is first captured in the request register, then its
// command runs against the worker table, where every cell compares and shifts
// in parallel. The next request is taken as soon as the previous one has been
// committed, even while its response still waits in the output register; a
// stalled response holds the block in its commit cycle. The table is kept in
// ascending ID order, packed from entry 0, and the turn passes upwards through
// it, wrapping from the last worker to the first. Registering an ID already
// present is accepted silently, and registering into a full table is refused.
// The job mailbox holds one word and survives the table becoming empty. IDs
// are stored at ID_BITS bits, taken from the low bits of the request field.
// ----------------------------------------------------------------------------
module round_robin_worker_dispatch_unit
   import rrwd_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   ctrl_cmd_type ctrl;

   // Sequencer: owns the handshakes and decides when a word is committed.
   rrwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // Datapath: the worker table, turn pointer, mailbox and response register.
   rrwd_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
